// File: hdl/tts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tts_pkg
// Shared types, codes and constants of the tick task scheduler.
// ============================================================================
package tts_pkg;

    // Default number of task slots.
    localparam int DEF_SLOT_COUNT = 8;

    // At most this many due events are reported for one tick.
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = 4;

    // Command codes of the input item.
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    // Event codes of the result item.
    localparam logic [2:0] EV_DUE        = 3'd0;
    localparam logic [2:0] EV_ADDED      = 3'd1;
    localparam logic [2:0] EV_DELETED    = 3'd2;
    localparam logic [2:0] EV_FULL       = 3'd3;
    localparam logic [2:0] EV_BAD_DELETE = 3'd4;

    // Sticky error codes.
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_FULL       = 2'd1;
    localparam logic [1:0] ERR_BAD_DELETE = 2'd2;

    // One entry of the slot table memory.
    typedef struct packed {
        logic [7:0]  tag;
        logic [15:0] reload;
        logic [16:0] countdown;
    } slot_ent_t;

    // One result waiting to be delivered.
    typedef struct packed {
        logic [2:0] event_res;
        logic [3:0] slot;
        logic [7:0] tag;
    } res_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK_SCAN,
        ST_TICK_UPD,
        ST_ADD_SCAN,
        ST_DEL_READ,
        ST_DEL_EXEC,
        ST_FLUSH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic tick_upd;
        logic add_exec;
        logic del_exec;
        logic flush;
        logic adv;
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] in_cmd;
        logic       scan_done;
        logic       cur_valid;
        logic       due;
        logic       room;
        logic       pend_valid;
        logic       out_free;
    } st_t;

endpackage
`default_nettype wire

// File: hdl/tick_task_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// A tick walks every slot, with an update step for each occupied slot; an add
//   scans for a free slot; a delete reads its slot, then acts on it.
// Items are taken one at a time, the next in the cycle after the last result
//   of the previous one is loaded; the slot walk through the single-port table
//   memory sets the pace.
// Reset (aresetn low, synchronous) empties every slot and clears the error.
// ============================================================================
// tick_task_scheduler
// Time-triggered cooperative scheduler table with tick, add and delete.
// ============================================================================
module tick_task_scheduler #(
    parameter int SLOT_COUNT = tts_pkg::DEF_SLOT_COUNT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [7:0]  s_task_tag,
    input  wire logic [15:0] s_first_delay,
    input  wire logic [15:0] s_repeat_period,
    input  wire logic [5:0]  s_slot_index,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_event_res,
    output logic [3:0]       m_slot,
    output logic [7:0]       m_due_tag,
    output logic [1:0]       m_error_code,
    output logic             m_last
);
    import tts_pkg::*;

    ctl_t ctl;
    st_t  st;

    // Sequencer.
    tts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .ctl     (ctl)
    );

    // Slot table and result path.
    tts_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctl             (ctl),
        .st              (st),
        .s_command       (s_command),
        .s_task_tag      (s_task_tag),
        .s_first_delay   (s_first_delay),
        .s_repeat_period (s_repeat_period),
        .s_slot_index    (s_slot_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_res     (m_event_res),
        .m_slot          (m_slot),
        .m_due_tag       (m_due_tag),
        .m_error_code    (m_error_code),
        .m_last          (m_last)
    );

endmodule
`default_nettype wire

// File: hdl/tts_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tts_datapath
// Slot table, scan index, pending result, sticky error and output register.
// ============================================================================
module tts_datapath #(
    parameter int SLOT_COUNT = tts_pkg::DEF_SLOT_COUNT
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire tts_pkg::ctl_t ctl,
    output tts_pkg::st_t      st,
    input  wire logic [1:0]   s_command,
    input  wire logic [7:0]   s_task_tag,
    input  wire logic [15:0]  s_first_delay,
    input  wire logic [15:0]  s_repeat_period,
    input  wire logic [5:0]   s_slot_index,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [2:0]        m_event_res,
    output logic [3:0]        m_slot,
    output logic [7:0]        m_due_tag,
    output logic [1:0]        m_error_code,
    output logic              m_last
);
    import tts_pkg::*;

    localparam int IW = $clog2(SLOT_COUNT + 1);
    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [6:0] SLOTS_W = 7'(SLOT_COUNT);
    localparam logic [3:0] SLOT_NONE = SLOTS_W[3:0];

    // Slot table: valid marks in flip-flops, the rest in a memory.
    logic [SLOT_COUNT-1:0] valid_reg, valid_next;
    slot_ent_t             mem [SLOT_COUNT];
    slot_ent_t             rd_reg;
    logic                  mem_we;
    slot_ent_t             mem_wdata;

    // Item fields held for the whole operation.
    logic [7:0]  tag_reg;
    logic [15:0] delay_reg;
    logic [15:0] period_reg;
    logic        oob_reg;

    // Scan index, event count, pending result and sticky error.
    logic [IW-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    res_t             pend_reg, pend_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [1:0]       err_reg, err_next;

    // Output register.
    logic       m_valid_reg, m_valid_next;
    res_t       out_reg;
    logic [1:0] out_err_reg;
    logic       out_last_reg;

    logic [AW-1:0] addr;
    logic [6:0]    idx_wide;
    logic [3:0]    cur_slot;
    logic [16:0]   dec;
    logic          due;
    logic          room;
    logic          out_free;
    logic          push_due;
    logic          out_load;

    assign addr     = idx_reg[AW-1:0];
    assign idx_wide = 7'(idx_reg);
    assign cur_slot = idx_wide[3:0];
    assign dec      = rd_reg.countdown - 17'd1;
    assign due      = (dec == 17'd0);
    assign room     = (cnt_reg < CNT_W'(MAX_RESULTS));
    assign out_free = !m_valid_reg || m_ready;
    assign push_due = ctl.tick_upd && due && room;
    assign out_load = ctl.flush || (push_due && pend_valid_reg);

    // Status toward the controller.
    always_comb begin
        st.in_cmd     = s_command;
        st.scan_done  = (idx_reg == IW'(SLOT_COUNT));
        st.cur_valid  = valid_reg[addr];
        st.due        = due;
        st.room       = room;
        st.pend_valid = pend_valid_reg;
        st.out_free   = out_free;
    end

    // Memory write data: countdown update on a tick, new entry on an add.
    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = rd_reg;
        if (ctl.tick_upd) begin
            mem_we = 1'b1;
            mem_wdata.countdown = due ? {1'b0, rd_reg.reload} : dec;
        end else if (ctl.add_exec && !st.scan_done) begin
            mem_we = 1'b1;
            mem_wdata.tag       = tag_reg;
            mem_wdata.reload    = period_reg;
            mem_wdata.countdown = {1'b0, delay_reg} + 17'd1;
        end
    end

    // Slot table memory with registered read at the scan index.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[addr] <= mem_wdata;
        end
        rd_reg <= mem[addr];
    end

    // Next values of the control registers.
    always_comb begin
        valid_next      = valid_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        err_next        = err_reg;
        if (ctl.accept) begin
            idx_next        = (s_command == CMD_DELETE) ? IW'(s_slot_index) : '0;
            cnt_next        = '0;
            pend_valid_next = 1'b0;
        end
        if (ctl.adv) begin
            idx_next = idx_reg + IW'(1);
        end
        if (ctl.tick_upd && due && rd_reg.reload == 16'd0) begin
            valid_next[addr] = 1'b0;
        end
        if (push_due) begin
            cnt_next        = cnt_reg + CNT_W'(1);
            pend_next       = '{event_res: EV_DUE, slot: cur_slot, tag: rd_reg.tag};
            pend_valid_next = 1'b1;
        end
        if (ctl.add_exec) begin
            pend_valid_next = 1'b1;
            if (st.scan_done) begin
                err_next  = ERR_FULL;
                pend_next = '{event_res: EV_FULL, slot: SLOT_NONE, tag: tag_reg};
            end else begin
                valid_next[addr] = 1'b1;
                pend_next = '{event_res: EV_ADDED, slot: cur_slot, tag: tag_reg};
            end
        end
        if (ctl.del_exec) begin
            pend_valid_next = 1'b1;
            if (oob_reg) begin
                err_next  = ERR_BAD_DELETE;
                pend_next = '{event_res: EV_BAD_DELETE, slot: SLOT_NONE, tag: 8'd0};
            end else if (!valid_reg[addr]) begin
                err_next  = ERR_BAD_DELETE;
                pend_next = '{event_res: EV_BAD_DELETE, slot: cur_slot, tag: 8'd0};
            end else begin
                valid_next[addr] = 1'b0;
                pend_next = '{event_res: EV_DELETED, slot: cur_slot, tag: rd_reg.tag};
            end
        end
        if (ctl.flush) begin
            pend_valid_next = 1'b0;
        end
    end

    // Output valid follows loads and takes.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            err_reg        <= ERR_NONE;
            m_valid_reg    <= 1'b0;
        end else begin
            valid_reg      <= valid_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            err_reg        <= err_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
        if (ctl.accept) begin
            tag_reg    <= s_task_tag;
            delay_reg  <= s_first_delay;
            period_reg <= s_repeat_period;
            oob_reg    <= ({1'b0, s_slot_index} >= SLOTS_W);
        end
        if (out_load) begin
            out_reg      <= pend_reg;
            out_err_reg  <= err_reg;
            out_last_reg <= ctl.flush;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_event_res  = out_reg.event_res;
    assign m_slot       = out_reg.slot;
    assign m_due_tag    = out_reg.tag;
    assign m_error_code = out_err_reg;
    assign m_last       = out_last_reg;

endmodule
`default_nettype wire

// File: hdl/tts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tts_ctrl
// Sequencer that steps the datapath through tick, add and delete operations.
// ============================================================================
module tts_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire tts_pkg::st_t  st,
    output tts_pkg::ctl_t      ctl
);
    import tts_pkg::*;

    state_t state_reg, state_next;
    logic   stall;

    // A due event cannot be recorded while the older one has nowhere to go.
    assign stall = st.due && st.room && st.pend_valid && !st.out_free;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (st.in_cmd)
                        CMD_TICK:   state_next = ST_TICK_SCAN;
                        CMD_ADD:    state_next = ST_ADD_SCAN;
                        CMD_DELETE: state_next = ST_DEL_READ;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_TICK_SCAN: begin
                if (st.scan_done) begin
                    state_next = ST_FLUSH;
                end else if (st.cur_valid) begin
                    state_next = ST_TICK_UPD;
                end
            end
            ST_TICK_UPD: begin
                if (!stall) begin
                    state_next = ST_TICK_SCAN;
                end
            end
            ST_ADD_SCAN: begin
                if (st.scan_done || !st.cur_valid) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_DEL_READ: state_next = ST_DEL_EXEC;
            ST_DEL_EXEC: state_next = ST_FLUSH;
            ST_FLUSH: begin
                if (!st.pend_valid || st.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        s_ready = 1'b0;
        ctl     = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                ctl.accept = s_valid;
            end
            ST_TICK_SCAN: begin
                ctl.adv = !st.scan_done && !st.cur_valid;
            end
            ST_TICK_UPD: begin
                ctl.tick_upd = !stall;
                ctl.adv      = !stall;
            end
            ST_ADD_SCAN: begin
                ctl.add_exec = st.scan_done || !st.cur_valid;
                ctl.adv      = !st.scan_done && st.cur_valid;
            end
            ST_DEL_EXEC: begin
                ctl.del_exec = 1'b1;
            end
            ST_FLUSH: begin
                ctl.flush = st.pend_valid && st.out_free;
            end
            default: begin
                ctl = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/tts_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tts_checker
// Port-level checks of the tick task scheduler, bound to the top level.
// ============================================================================
module tts_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [2:0] m_event_res,
    input wire logic [3:0] m_slot,
    input wire logic [7:0] m_due_tag,
    input wire logic [1:0] m_error_code,
    input wire logic       m_last
);
    import tts_pkg::*;

    // A stalled result item holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_res) && $stable(m_slot)
            && $stable(m_due_tag) && $stable(m_error_code) && $stable(m_last))
        else $error("result item changed while stalled");

    // No result item is offered right after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Add and delete produce a single result item.
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res != EV_DUE |-> m_last)
        else $error("add or delete result not marked last");

    // A full-table rejection reports the full error.
    a_full_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res == EV_FULL |-> m_error_code == ERR_FULL)
        else $error("full rejection without full error");

    // A bad delete reports the bad delete error.
    a_del_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res == EV_BAD_DELETE |-> m_error_code == ERR_BAD_DELETE)
        else $error("bad delete without bad delete error");

endmodule

bind tick_task_scheduler tts_checker u_tts_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_event_res  (m_event_res),
    .m_slot       (m_slot),
    .m_due_tag    (m_due_tag),
    .m_error_code (m_error_code),
    .m_last       (m_last)
);
`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the tick task scheduler: directed and random items.
// Tick, add, delete and unused commands are driven through the input channel
// with random gaps. A table model in the bench predicts every result item,
// and each one is compared field by field as it leaves the block.
// ============================================================================
module tb;
    import tts_pkg::*;

    localparam int SLOTS         = DEF_SLOT_COUNT;
    localparam int SETTLE_CYCLES = 40;
    localparam int IDLE_PERCENT  = 37;
    localparam int RANDOM_ITEMS  = 175;

    // The one command code that the block ignores.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // One result item as the block should deliver it.
    typedef struct packed {
        logic [2:0] event_res;
        logic [3:0] slot;
        logic [7:0] due_tag;
        logic [1:0] error_code;
        logic       last;
    } sched_event_t;

    logic        aclk;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command       = CMD_TICK;
    logic [7:0]  s_task_tag      = 8'd0;
    logic [15:0] s_first_delay   = 16'd0;
    logic [15:0] s_repeat_period = 16'd0;
    logic [5:0]  s_slot_index    = 6'd0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [2:0]  m_event_res;
    logic [3:0]  m_slot;
    logic [7:0]  m_due_tag;
    logic [1:0]  m_error_code;
    logic        m_last;

    // Shadow copy of the slot table.
    logic        tbl_valid  [SLOTS];
    logic [16:0] tbl_count  [SLOTS];
    logic [15:0] tbl_reload [SLOTS];
    logic [7:0]  tbl_tag    [SLOTS];
    logic [1:0]  tbl_error;

    sched_event_t expected_events[$];

    // Steady flow turns off idling on both sides.
    logic steady_flow = 1'b0;

    int fail_count   = 0;
    int cmds_sent    = 0;
    int noise_sent   = 0;
    int events_seen  = 0;
    int due_seen     = 0;
    int full_seen    = 0;
    int bad_del_seen = 0;

    tick_task_scheduler #(
        .SLOT_COUNT(SLOTS)
    ) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_task_tag     (s_task_tag),
        .s_first_delay  (s_first_delay),
        .s_repeat_period(s_repeat_period),
        .s_slot_index   (s_slot_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_res    (m_event_res),
        .m_slot         (m_slot),
        .m_due_tag      (m_due_tag),
        .m_error_code   (m_error_code),
        .m_last         (m_last)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #1_000_000;
        $display("[tick_task_scheduler] ERROR");
        $finish;
    end

    // Result side back-pressure.
    always @(posedge aclk) begin
        m_ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Compare each accepted result item with the oldest prediction.
    always @(posedge aclk) begin
        sched_event_t want;
        if (aresetn && m_valid && m_ready) begin
            events_seen++;
            if (m_event_res == EV_DUE) due_seen++;
            if (m_event_res == EV_FULL) full_seen++;
            if (m_event_res == EV_BAD_DELETE) bad_del_seen++;
            if (expected_events.size() == 0) begin
                fail_count++;
                $error("unexpected result: event_res %0d slot %0d due_tag %0d",
                       m_event_res, m_slot, m_due_tag);
            end else begin
                want = expected_events.pop_front();
                if (m_event_res !== want.event_res) begin
                    fail_count++;
                    $error("event_res: expected %0d, got %0d", want.event_res, m_event_res);
                end
                if (m_slot !== want.slot) begin
                    fail_count++;
                    $error("slot: expected %0d, got %0d", want.slot, m_slot);
                end
                if (m_due_tag !== want.due_tag) begin
                    fail_count++;
                    $error("due_tag: expected %0d, got %0d", want.due_tag, m_due_tag);
                end
                if (m_error_code !== want.error_code) begin
                    fail_count++;
                    $error("error_code: expected %0d, got %0d",
                           want.error_code, m_error_code);
                end
                if (m_last !== want.last) begin
                    fail_count++;
                    $error("last: expected %0d, got %0d", want.last, m_last);
                end
            end
        end
    end

    // Empty one slot of the shadow table.
    task automatic clear_table_slot(input int idx);
        tbl_valid[idx]  = 1'b0;
        tbl_count[idx]  = 17'd0;
        tbl_reload[idx] = 16'd0;
        tbl_tag[idx]    = 8'd0;
    endtask

    // Apply one accepted command to the shadow table and queue its results.
    task automatic schedule_step(input logic [1:0] cmd, input logic [7:0] tag,
                                 input logic [15:0] dly, input logic [15:0] per,
                                 input logic [5:0] idx);
        sched_event_t batch[$];
        sched_event_t ev;
        int free_slot;
        ev = '0;
        free_slot = 0;
        case (cmd)
            CMD_TICK: begin
                // Walk the slots in order; due tasks reload or retire.
                for (int i = 0; i < SLOTS; i++) begin
                    if (tbl_valid[i]) begin
                        tbl_count[i] = tbl_count[i] - 17'd1;
                        if (tbl_count[i] == 17'd0) begin
                            if (batch.size() < MAX_RESULTS) begin
                                ev.event_res = EV_DUE;
                                ev.slot      = 4'(i);
                                ev.due_tag   = tbl_tag[i];
                                batch.push_back(ev);
                            end
                            if (tbl_reload[i] != 16'd0) begin
                                tbl_count[i] = {1'b0, tbl_reload[i]};
                            end else begin
                                clear_table_slot(i);
                            end
                        end
                    end
                end
            end
            CMD_ADD: begin
                // The lowest free slot takes the task.
                while (free_slot < SLOTS && tbl_valid[free_slot]) free_slot++;
                ev.due_tag = tag;
                if (free_slot >= SLOTS) begin
                    tbl_error    = ERR_FULL;
                    ev.event_res = EV_FULL;
                    ev.slot      = 4'(SLOTS);
                end else begin
                    tbl_valid[free_slot]  = 1'b1;
                    tbl_tag[free_slot]    = tag;
                    tbl_count[free_slot]  = {1'b0, dly} + 17'd1;
                    tbl_reload[free_slot] = per;
                    ev.event_res = EV_ADDED;
                    ev.slot      = 4'(free_slot);
                end
                batch.push_back(ev);
            end
            CMD_DELETE: begin
                if (idx >= SLOTS) begin
                    tbl_error    = ERR_BAD_DELETE;
                    ev.event_res = EV_BAD_DELETE;
                    ev.slot      = 4'(SLOTS);
                    ev.due_tag   = 8'd0;
                end else if (!tbl_valid[idx]) begin
                    tbl_error    = ERR_BAD_DELETE;
                    clear_table_slot(idx);
                    ev.event_res = EV_BAD_DELETE;
                    ev.slot      = 4'(idx);
                    ev.due_tag   = 8'd0;
                end else begin
                    ev.event_res = EV_DELETED;
                    ev.slot      = 4'(idx);
                    ev.due_tag   = tbl_tag[idx];
                    clear_table_slot(idx);
                end
                batch.push_back(ev);
            end
            default: begin
            end
        endcase
        // Every result carries the error after this command; the final one is marked.
        foreach (batch[k]) begin
            batch[k].error_code = tbl_error;
            batch[k].last       = (k == batch.size() - 1);
            expected_events.push_back(batch[k]);
        end
    endtask

    // Offer one item, wait for it to be taken, then predict its results.
    task automatic send_command(input logic [1:0] cmd, input logic [7:0] tag,
                                input logic [15:0] dly, input logic [15:0] per,
                                input logic [5:0] idx);
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_command       <= cmd;
        s_task_tag      <= tag;
        s_first_delay   <= dly;
        s_repeat_period <= per;
        s_slot_index    <= idx;
        do @(posedge aclk); while (!s_ready);
        if (cmd == CMD_UNUSED) noise_sent++;
        else cmds_sent++;
        schedule_step(cmd, tag, dly, per, idx);
    endtask

    // Hold the input side off until every predicted result has come out.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Empty ticks, a one-shot task and the ignored command code.
    task automatic test_one_shot();
        send_command(CMD_TICK, 8'h00, 16'd0, 16'd0, 6'd0);
        send_command(CMD_ADD, 8'hA5, 16'd0, 16'd0, 6'd0);
        send_command(CMD_TICK, 8'h00, 16'd0, 16'd0, 6'd0);
        send_command(CMD_TICK, 8'h00, 16'd0, 16'd0, 6'd0);
        send_command(CMD_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF, 6'h3F);
    endtask

    // Largest field values, a period of one, and deletes of live slots.
    task automatic test_field_extremes();
        send_command(CMD_ADD, 8'hFF, 16'hFFFF, 16'hFFFF, 6'h3F);
        send_command(CMD_ADD, 8'h00, 16'd0, 16'd1, 6'd0);
        send_command(CMD_TICK, 8'h00, 16'd0, 16'd0, 6'd0);
        send_command(CMD_DELETE, 8'h00, 16'd0, 16'd0, 6'd0);
        send_command(CMD_DELETE, 8'h00, 16'd0, 16'd0, 6'd1);
    endtask

    // Fill the table, overflow it, fire every slot on one tick, then bad deletes and a live delete.
    task automatic test_full_table();
        for (int i = 0; i < SLOTS; i++) begin
            send_command(CMD_ADD, 8'(8'h10 + i), 16'd2, 16'(i % 2), 6'd0);
        end
        send_command(CMD_ADD, 8'h77, 16'd5, 16'd5, 6'd0);
        repeat (3) send_command(CMD_TICK, 8'h00, 16'd0, 16'd0, 6'd0);
        send_command(CMD_DELETE, 8'h00, 16'd0, 16'd0, 6'(SLOTS));
        send_command(CMD_DELETE, 8'h00, 16'd0, 16'd0, 6'h3F);
        send_command(CMD_DELETE, 8'h00, 16'd0, 16'd0, 6'd0);
        send_command(CMD_DELETE, 8'h00, 16'd0, 16'd0, 6'd1);
    endtask

    // Mostly short-lived tasks and frequent ticks, with some wide values and noise.
    task automatic test_random_traffic(input int n_items);
        int sent;
        int pick;
        logic paused;
        logic [15:0] dly;
        logic [15:0] per;
        logic [5:0]  idx;
        sent   = 0;
        paused = 1'b0;
        while (sent < n_items) begin
            if (!paused && sent == n_items / 3) begin
                drain_results();
                paused = 1'b1;
            end
            steady_flow = (sent >= n_items / 2) && (sent < n_items / 2 + 50);
            pick = $urandom_range(0, 99);
            dly  = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 6))
                                                : 16'($urandom_range(0, 65535));
            pick = pick;
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7: per = 16'd0;
                8, 9, 10, 11, 12, 13, 14, 15, 16: per = 16'($urandom_range(1, 8));
                default: per = 16'($urandom_range(0, 65535));
            endcase
            idx = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, SLOTS - 1))
                                              : 6'($urandom_range(0, 63));
            if (pick < 45) begin
                send_command(CMD_TICK, 8'($urandom), dly, per, idx);
                sent++;
            end else if (pick < 75) begin
                send_command(CMD_ADD, 8'($urandom), dly, per, idx);
                sent++;
            end else if (pick < 93) begin
                send_command(CMD_DELETE, 8'($urandom), dly, per, idx);
                sent++;
            end else begin
                send_command(CMD_UNUSED, 8'($urandom), dly, per, idx);
            end
        end
        steady_flow = 1'b0;
    endtask

    // Main sequence.
    initial begin
        for (int i = 0; i < SLOTS; i++) clear_table_slot(i);
        tbl_error = ERR_NONE;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_one_shot();
        test_field_extremes();
        test_full_table();
        test_random_traffic(RANDOM_ITEMS);
        drain_results();
        if (expected_events.size() != 0) begin
            fail_count++;
            $error("%0d predicted results never arrived", expected_events.size());
        end
        $display("Run covered %0d commands and %0d ignored items; %0d results checked.",
                 cmds_sent, noise_sent, events_seen);
        $display("Results included %0d due events, %0d full rejections, %0d bad deletes.",
                 due_seen, full_seen, bad_del_seen);
        if (fail_count == 0) begin
            $display("[tick_task_scheduler] OK");
        end else begin
            $display("[tick_task_scheduler] ERROR");
        end
        $finish;
    end

endmodule
